// File: rtl/tdc_pkg.sv
`timescale 1ns / 1ps
package tdc_pkg;

   localparam logic CMD_TO_DURATION = 1'b0;
   localparam logic CMD_TO_UNITS    = 1'b1;

   localparam logic REG_NUMERATOR   = 1'b0;
   localparam logic REG_DENOMINATOR = 1'b1;

   localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;
   localparam logic [63:0] HALF_SEC_NS = 64'd500000000;
   localparam logic [63:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;

   // one cell per quotient bit
   localparam int DIV1_STEPS = 96;
   localparam int DIV2_STEPS = 64;

   typedef struct packed {
      logic        cmd;
      logic        neg;
      logic        xneg;
      logic        ovf;
      logic [31:0] den;
      logic [63:0] base;
      logic [63:0] dval;
      logic [63:0] val;
   } ctx_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [95:0] work;
      logic [63:0] dvs;
      ctx_type     ctx;
   } stage_type;

   typedef struct packed {
      logic [63:0] secs;
      logic [29:0] ns;
      logic [63:0] units;
   } result_type;

endpackage

// File: rtl/tdc_div_cell.sv
`timescale 1ns / 1ps
module tdc_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  tdc_pkg::stage_type  in_stage,
   output logic                out_valid,
   output tdc_pkg::stage_type  out_stage
);

   logic               valid_ff;
   tdc_pkg::stage_type stage_ff;
   tdc_pkg::stage_type stage_in;
   logic [64:0]        trial;
   logic [65:0]        diff;
   logic               fit;

   // shift in the next dividend bit, subtract the divisor if it fits
   always_comb begin
      trial    = {in_stage.rem, in_stage.work[95]};
      diff     = {1'b0, trial} - {2'b00, in_stage.dvs};
      fit      = ~diff[65];
      stage_in = in_stage;
      stage_in.rem  = fit ? diff[63:0] : trial[63:0];
      stage_in.work = {in_stage.work[94:0], fit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// File: rtl/tdc_front.sv
`timescale 1ns / 1ps
module tdc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic                cmd,
   input  logic [63:0]         unit_count,
   input  logic [63:0]         in_seconds,
   input  logic [29:0]         in_nanoseconds,
   input  logic [31:0]         numerator,
   input  logic [31:0]         denominator,
   output logic                out_valid,
   output tdc_pkg::stage_type  out_stage
);

   logic        v0_ff, v1_ff, v2_ff;
   logic        cmd0_ff, neg0_ff, cmd1_ff, neg1_ff;
   logic [63:0] mag0_ff;
   logic [31:0] num0_ff, den0_ff, num1_ff, den1_ff;
   logic [29:0] ns0_ff;
   logic [63:0] pl_ff, ph_ff, nsd_ff, nh_ff, dv_ff;
   logic [63:0] src;
   logic [31:0] mulv;
   logic [95:0] prod;
   logic [63:0] lim, spmag;
   tdc_pkg::stage_type stage_in, stage_ff;

   assign src  = (cmd == tdc_pkg::CMD_TO_UNITS) ? in_seconds : unit_count;
   assign mulv = (cmd0_ff == tdc_pkg::CMD_TO_UNITS) ? den0_ff : num0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // a zero register acts as one
   always_ff @(posedge clock) begin
      if (en) begin
         cmd0_ff <= cmd;
         neg0_ff <= src[63];
         mag0_ff <= src[63] ? (64'd0 - src) : src;
         num0_ff <= (numerator == 32'd0) ? 32'd1 : numerator;
         den0_ff <= (denominator == 32'd0) ? 32'd1 : denominator;
         ns0_ff  <= in_nanoseconds;

         cmd1_ff <= cmd0_ff;
         neg1_ff <= neg0_ff;
         num1_ff <= num0_ff;
         den1_ff <= den0_ff;
         pl_ff   <= 64'(mag0_ff[31:0]) * 64'(mulv);
         ph_ff   <= 64'(mag0_ff[63:32]) * 64'(mulv);
         nsd_ff  <= 64'(ns0_ff) * 64'(den0_ff);
         nh_ff   <= 64'(num0_ff) * tdc_pkg::HALF_SEC_NS;
         dv_ff   <= 64'(num0_ff) * tdc_pkg::NS_PER_SEC;

         stage_ff <= stage_in;
      end
   end

   // saturate seconds times denominator to the signed range for the units path
   always_comb begin
      prod  = {32'd0, pl_ff} + {ph_ff, 32'd0};
      lim   = neg1_ff ? tdc_pkg::S64_MIN : tdc_pkg::S64_MAX;
      spmag = ((|prod[95:64]) || (prod[63:0] > lim)) ? lim : prod[63:0];
      stage_in          = '0;
      stage_in.ctx.cmd  = cmd1_ff;
      stage_in.ctx.neg  = neg1_ff;
      stage_in.ctx.den  = den1_ff;
      stage_in.ctx.base = nsd_ff + nh_ff;
      stage_in.ctx.dval = dv_ff;
      if (cmd1_ff == tdc_pkg::CMD_TO_UNITS) begin
         stage_in.work = {32'd0, spmag};
         stage_in.dvs  = {32'd0, num1_ff};
      end else begin
         stage_in.work = prod;
         stage_in.dvs  = {32'd0, den1_ff};
      end
   end

   assign out_valid = v2_ff;
   assign out_stage = stage_ff;

endmodule

// File: rtl/tdc_mid.sv
`timescale 1ns / 1ps
module tdc_mid (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  tdc_pkg::stage_type  in_stage,
   output logic                out_valid,
   output tdc_pkg::stage_type  out_stage
);

   logic               v1_ff, v2_ff, v3_ff;
   tdc_pkg::stage_type s1_ff, s2_ff, s3_ff;
   tdc_pkg::stage_type s1_in, s2_in, s3_in;
   logic [63:0] qlo, qinc;
   logic        rnz, ovf;
   logic [64:0] xs;
   logic [63:0] xmag;

   // sign fix of the first quotient, overflow of the seconds
   always_comb begin
      qlo  = in_stage.work[63:0];
      rnz  = |in_stage.rem[31:0];
      s1_in      = in_stage;
      s1_in.work = '0;
      s1_in.rem  = {32'd0, in_stage.rem[31:0]};
      s1_in.ctx.val = qlo;
      s1_in.ctx.ovf = 1'b0;
      qinc = qlo;
      ovf  = |in_stage.work[95:64];
      if (in_stage.ctx.cmd == tdc_pkg::CMD_TO_DURATION) begin
         if (in_stage.ctx.neg) begin
            if (rnz) begin
               if (&qlo) begin
                  ovf = 1'b1;
               end else begin
                  qinc = qlo + 64'd1;
               end
               s1_in.rem = {32'd0, in_stage.ctx.den - in_stage.rem[31:0]};
            end
            if (qinc > tdc_pkg::S64_MIN) begin
               ovf = 1'b1;
            end
            s1_in.ctx.val = 64'd0 - qinc;
         end else begin
            if (qlo[63]) begin
               ovf = 1'b1;
            end
         end
         s1_in.ctx.ovf = ovf;
      end
   end

   always_comb begin
      s2_in     = s1_ff;
      s2_in.rem = 64'(s1_ff.rem[31:0]) * tdc_pkg::NS_PER_SEC;
   end

   // build the second dividend: rounded nanoseconds, or the floored unit adjustment
   always_comb begin
      s3_in = s2_ff;
      s3_in.rem = '0;
      xs   = '0;
      xmag = '0;
      if (s2_ff.ctx.cmd == tdc_pkg::CMD_TO_DURATION) begin
         s3_in.work = {s2_ff.rem + {33'd0, s2_ff.ctx.den[31:1]}, 32'd0};
         s3_in.dvs  = {32'd0, s2_ff.ctx.den};
      end else begin
         xs = s2_ff.ctx.neg ? ({1'b0, s2_ff.ctx.base} - {1'b0, s2_ff.rem})
                            : ({1'b0, s2_ff.ctx.base} + {1'b0, s2_ff.rem});
         xmag = xs[64] ? (64'd0 - xs[63:0]) : xs[63:0];
         s3_in.ctx.xneg = xs[64];
         s3_in.work = {xmag, 32'd0};
         s3_in.dvs  = s2_ff.ctx.dval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_stage = s3_ff;

endmodule

// File: rtl/tdc_back.sv
`timescale 1ns / 1ps
module tdc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  tdc_pkg::stage_type  in_stage,
   output logic                out_valid,
   output tdc_pkg::result_type out_result
);

   logic                valid_ff;
   tdc_pkg::result_type result_ff, result_in;
   logic [63:0] q;
   logic [65:0] aq, adj, qs, sum;

   always_comb begin
      q   = in_stage.work[63:0];
      aq  = '0;
      adj = '0;
      qs  = '0;
      sum = '0;
      result_in = '0;
      if (in_stage.ctx.cmd == tdc_pkg::CMD_TO_DURATION) begin
         result_in.secs = in_stage.ctx.val;
         result_in.ns   = q[29:0];
         if (in_stage.ctx.ovf) begin
            result_in.secs = in_stage.ctx.neg ? tdc_pkg::S64_MIN : tdc_pkg::S64_MAX;
            result_in.ns   = '0;
         end else if (q == tdc_pkg::NS_PER_SEC) begin
            // rounding reached a full second: carry, hold at the top
            result_in.ns = '0;
            if (in_stage.ctx.val != tdc_pkg::S64_MAX) begin
               result_in.secs = in_stage.ctx.val + 64'd1;
            end
         end
      end else begin
         aq  = {2'b00, q} + {65'd0, (in_stage.ctx.xneg && (|in_stage.rem))};
         adj = in_stage.ctx.xneg ? (66'd0 - aq) : aq;
         qs  = in_stage.ctx.neg ? (66'd0 - {2'b00, in_stage.ctx.val})
                                : {2'b00, in_stage.ctx.val};
         sum = qs + adj;
         if (sum[65] && !(sum[64] && sum[63])) begin
            result_in.units = tdc_pkg::S64_MIN;
         end else if (!sum[65] && (sum[64] || sum[63])) begin
            result_in.units = tdc_pkg::S64_MAX;
         end else begin
            result_in.units = sum[63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// File: rtl/timebase_duration_converter_core.sv
`timescale 1ns / 1ps
// Converts between a signed count of time units (numerator/denominator seconds
// each) and a duration of floored seconds plus nanoseconds.
// req_cmd low: req_unit_count gives rsp_out_seconds and rsp_out_nanoseconds.
// req_cmd high: req_in_seconds and req_in_nanoseconds give rsp_out_units.
// Fields a command does not produce read as zero.
// A beat moves on either channel when valid is high and stall is low.
// csr_we with csr_index 0 writes the numerator, index 1 the denominator,
// from csr_wdata; write them only while no beat is in flight.
// Throughput: one beat per cycle while the response is not stalled.
// The pipeline is two chains of divider cells (96 quotient bits, then 64),
// one bit per cell, plus multiply, fix-up and output stages around them.
// When the response stalls, one more beat lands in a skid register and then
// the whole pipeline holds and req_stall rises until the response drains.
// Reset clears all valid flags and sets both registers to one; a zero
// register acts as one.
module timebase_duration_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [63:0] req_unit_count,
   input  logic [63:0] req_in_seconds,
   input  logic [29:0] req_in_nanoseconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_seconds,
   output logic [29:0] rsp_out_nanoseconds,
   output logic [63:0] rsp_out_units,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] num_ff, den_ff;
   logic        en, push, take;
   logic        out_v_ff, skid_v_ff;
   tdc_pkg::result_type out_ff, skid_ff, tail_result;
   logic        tail_v;

   logic               c1_v [0:tdc_pkg::DIV1_STEPS];
   tdc_pkg::stage_type c1_s [0:tdc_pkg::DIV1_STEPS];
   logic               c2_v [0:tdc_pkg::DIV2_STEPS];
   tdc_pkg::stage_type c2_s [0:tdc_pkg::DIV2_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= 32'd1;
         den_ff <= 32'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            tdc_pkg::REG_NUMERATOR:   num_ff <= csr_wdata;
            tdc_pkg::REG_DENOMINATOR: den_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = ~skid_v_ff;
   assign req_stall = skid_v_ff;

   tdc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (req_valid),
      .cmd            (req_cmd),
      .unit_count     (req_unit_count),
      .in_seconds     (req_in_seconds),
      .in_nanoseconds (req_in_nanoseconds),
      .numerator      (num_ff),
      .denominator    (den_ff),
      .out_valid      (c1_v[0]),
      .out_stage      (c1_s[0])
   );

   for (genvar i = 0; i < tdc_pkg::DIV1_STEPS; i++) begin : g_div1
      tdc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (c1_v[i]),
         .in_stage  (c1_s[i]),
         .out_valid (c1_v[i+1]),
         .out_stage (c1_s[i+1])
      );
   end

   tdc_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c1_v[tdc_pkg::DIV1_STEPS]),
      .in_stage  (c1_s[tdc_pkg::DIV1_STEPS]),
      .out_valid (c2_v[0]),
      .out_stage (c2_s[0])
   );

   for (genvar i = 0; i < tdc_pkg::DIV2_STEPS; i++) begin : g_div2
      tdc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (c2_v[i]),
         .in_stage  (c2_s[i]),
         .out_valid (c2_v[i+1]),
         .out_stage (c2_s[i+1])
      );
   end

   tdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (c2_v[tdc_pkg::DIV2_STEPS]),
      .in_stage   (c2_s[tdc_pkg::DIV2_STEPS]),
      .out_valid  (tail_v),
      .out_result (tail_result)
   );

   assign push = en & tail_v;
   assign take = out_v_ff & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_v_ff && !take) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_v_ff && !take) begin
            skid_ff <= tail_result;
         end else begin
            out_ff <= tail_result;
         end
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_out_seconds     = out_ff.secs;
   assign rsp_out_nanoseconds = out_ff.ns;
   assign rsp_out_units       = out_ff.units;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a beat while the output register is empty");

   a_tail_frozen: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && tail_v) |=> (tail_v && $stable(tail_result)))
      else $error("pipeline advanced while the skid register was full");

   a_stall_catch: assert property (@(posedge clock) disable iff (reset)
      (!skid_v_ff && tail_v && out_v_ff && rsp_stall) |=> skid_v_ff)
      else $error("beat dropped behind a stalled response");
`endif

endmodule
